/* rtl/core/gradient_shade_palette_gen_core_defines.svh */
// Assertion macros shared by the gradient shade palette core.
`ifndef GRADIENT_SHADE_PALETTE_GEN_CORE_DEFINES_SVH
`define GRADIENT_SHADE_PALETTE_GEN_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GSP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/gsp_pkg.sv */
// Package: constants, types and helpers of the gradient shade palette core.
`timescale 1ns / 1ps
package gsp_pkg;

  localparam int GRADIENT_LINES  = 32;
  localparam int SHADES_PER_LINE = 16;
  localparam int FIRST_RAMP_LINE = 2;
  localparam int RAMP_DIV        = GRADIENT_LINES - FIRST_RAMP_LINE;

  localparam int CH_W       = 5;
  localparam int NUM_CH     = 3;
  localparam int COLOR_W    = 15;
  localparam int SHADE_W    = 4;
  localparam int COEFF_W    = 5;
  localparam int COEFF_MAX  = 16;
  localparam int LINE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_W      = 3;
  localparam int DIM_BASE   = 2;
  localparam int FADE_SHIFT = 4;

  localparam logic [SHADE_W-1:0] SHADE_LAST = SHADE_W'(SHADES_PER_LINE - 1);

  // clamped line number and ramp offset k
  localparam int LN_W   = $clog2(GRADIENT_LINES);
  localparam int LCMP_W = ((LINE_W > LN_W) ? LINE_W : LN_W) + 1;
  // ramp step: |stop*8 - start*8| / RAMP_DIV, plus sign
  localparam int STEP_MAG_W = CH_W + 3;
  localparam int STEP_W     = STEP_MAG_W + 1;
  localparam int STEP_TAB_N = 1 << CH_W;
  localparam int PROD_W     = LN_W + 1 + STEP_W;
  localparam int SUM_W      = PROD_W + 1;
  // fade product: signed channel difference times coefficient
  localparam int FADE_W     = CH_W + 1 + COEFF_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_COLOR = 2'd0,
    REG_STOP_COLOR  = 2'd1,
    REG_BLEND_COEFF = 2'd2,
    REG_FADE_COLOR  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] stop_color;
    logic [COEFF_W-1:0] blend_coeff;
    logic [COLOR_W-1:0] fade_color;
  } cfg_t;

  // one shade entry handed from the sequencer to the shade pipeline
  typedef struct packed {
    logic                           ramp;
    logic [LN_W-1:0]                k;
    logic [NUM_CH-1:0][STEP_W-1:0]  step;
    logic [SHADE_W-1:0]             shade;
  } issue_t;

  typedef logic [STEP_MAG_W-1:0] step_tab_t [STEP_TAB_N];

  // (8 * channel distance) / RAMP_DIV for every 5-bit distance
  function automatic step_tab_t build_step_tab();
    step_tab_t tab;
    for (int i = 0; i < STEP_TAB_N; i++) begin
      tab[i] = STEP_MAG_W'((i * 8) / RAMP_DIV);
    end
    return tab;
  endfunction

  localparam step_tab_t STEP_TAB = build_step_tab();

  function automatic logic [CH_W-1:0] chan(input logic [COLOR_W-1:0] c, input int p);
    return c[p*CH_W +: CH_W];
  endfunction

endpackage

/* rtl/core/gsp_cfg_if.sv */
// Interface: configuration write channel.
`timescale 1ns / 1ps
interface gsp_cfg_if import gsp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/gsp_line_if.sv */
// Interface: line request channel.
`timescale 1ns / 1ps
interface gsp_line_if import gsp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_index;

  modport source (output valid, line_index, input ready);
  modport sink   (input valid, line_index, output ready);
endinterface

/* rtl/core/gsp_entry_if.sv */
// Interface: palette entry result channel.
`timescale 1ns / 1ps
interface gsp_entry_if import gsp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] palette_color;
  logic [SHADE_W-1:0] shade_index;
  logic               last_shade;

  modport source (output valid, palette_color, shade_index, last_shade, input ready);
  modport sink   (input valid, palette_color, shade_index, last_shade, output ready);
endinterface

/* rtl/core/gsp_cfg_regs.sv */
// Configuration register file.
`timescale 1ns / 1ps
module gsp_cfg_regs import gsp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  gsp_cfg_if.sink cfg,
  output cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_START_COLOR: regs.start_color <= cfg.data;
        REG_STOP_COLOR:  regs.stop_color  <= cfg.data;
        REG_BLEND_COEFF: regs.blend_coeff <= cfg.data[COEFF_W-1:0];
        REG_FADE_COLOR:  regs.fade_color  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/gsp_line_seq.sv */
// Line sequencer: takes a line request and issues its 16 shade words.
`timescale 1ns / 1ps
`include "gradient_shade_palette_gen_core_defines.svh"
module gsp_line_seq import gsp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     regs,
  gsp_line_if.sink req,
  output logic     issue_valid,
  output issue_t   issue,
  input  logic     issue_ready
);

  logic                          busy;
  logic [SHADE_W-1:0]            shade;
  logic                          ramp;
  logic [LN_W-1:0]               k;
  logic [NUM_CH-1:0][STEP_W-1:0] step;

  logic                          accept;
  logic [LCMP_W-1:0]             line_ext;
  logic [LN_W-1:0]               line_cl;
  logic [NUM_CH-1:0][STEP_W-1:0] step_next;

  assign req.ready = !busy || ((shade == SHADE_LAST) && issue_ready);
  assign accept    = req.valid && req.ready;

  // clamp to the last line, then per-channel signed step from the table
  always_comb begin
    logic [CH_W-1:0]       s, e, a;
    logic [STEP_MAG_W-1:0] mag;
    line_ext = LCMP_W'(req.line_index);
    if (line_ext >= LCMP_W'(GRADIENT_LINES)) begin
      line_cl = LN_W'(GRADIENT_LINES - 1);
    end else begin
      line_cl = LN_W'(line_ext);
    end
    for (int p = 0; p < NUM_CH; p++) begin
      s   = chan(regs.start_color, p);
      e   = chan(regs.stop_color, p);
      a   = (e < s) ? (s - e) : (e - s);
      mag = STEP_TAB[a];
      step_next[p] = (e < s) ? (STEP_W'(0) - {1'b0, mag}) : {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      shade <= '0;
    end else if (accept) begin
      busy  <= 1'b1;
      shade <= '0;
    end else if (busy && issue_ready) begin
      if (shade == SHADE_LAST) begin
        busy <= 1'b0;
      end
      shade <= shade + SHADE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ramp <= (line_cl >= LN_W'(FIRST_RAMP_LINE));
      k    <= line_cl - LN_W'(FIRST_RAMP_LINE);
      step <= step_next;
    end
  end

  assign issue_valid = busy;
  assign issue.ramp  = ramp;
  assign issue.k     = k;
  assign issue.step  = step;
  assign issue.shade = shade;

  `GSP_ASSERT_IMPL(a_no_mid_line_accept, accept && busy, shade == SHADE_LAST, "line taken mid-line")
  `GSP_ASSERT_NEXT(a_shade_advance, busy && issue_ready && (shade != SHADE_LAST) && !accept, busy && (shade == $past(shade) + SHADE_W'(1)), "shade count skipped")

endmodule

/* rtl/core/gsp_shade_pipe.sv */
// Shade pipeline: ramp multiply, base and dim, fade multiply, fade add.
`timescale 1ns / 1ps
`include "gradient_shade_palette_gen_core_defines.svh"
module gsp_shade_pipe import gsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         regs,
  input  logic         issue_valid,
  input  issue_t       issue,
  output logic         issue_ready,
  gsp_entry_if.source  palette
);

  // stage valids and readies
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  // stage 1: k * step
  logic                                  ramp1;
  logic [SHADE_W-1:0]                    shade1;
  logic [NUM_CH-1:0][PROD_W-1:0]         prod1;
  // stage 2: dimmed base channel
  logic [SHADE_W-1:0]                    shade2;
  logic [NUM_CH-1:0][CH_W-1:0]           c2;
  // stage 3: fade product
  logic [SHADE_W-1:0]                    shade3;
  logic [NUM_CH-1:0][CH_W-1:0]           c3;
  logic [NUM_CH-1:0][FADE_W-1:0]         d3;
  // stage 4: output word
  logic [COLOR_W-1:0]                    color4;
  logic [SHADE_W-1:0]                    shade4;

  logic [NUM_CH-1:0][PROD_W-1:0]         prod1_next;
  logic [NUM_CH-1:0][CH_W-1:0]           c2_next;
  logic [NUM_CH-1:0][FADE_W-1:0]         d3_next;
  logic [COLOR_W-1:0]                    color4_next;
  logic [COEFF_W-1:0]                    coeff_cl;

  assign r4          = !v4 || palette.ready;
  assign r3          = !v3 || r4;
  assign r2          = !v2 || r3;
  assign r1          = !v1 || r2;
  assign issue_ready = r1;

  assign coeff_cl = (regs.blend_coeff > COEFF_W'(COEFF_MAX)) ? COEFF_W'(COEFF_MAX)
                                                             : regs.blend_coeff;

  always_comb begin
    for (int p = 0; p < NUM_CH; p++) begin
      prod1_next[p] = PROD_W'($signed({1'b0, issue.k}) * $signed(issue.step[p]));
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] v;
    logic [CH_W-1:0]         base;
    logic [DIM_W-1:0]        dim;
    dim = DIM_W'(shade1 >> 2) + DIM_W'(DIM_BASE);
    for (int p = 0; p < NUM_CH; p++) begin
      v = $signed(SUM_W'({chan(regs.start_color, p), 3'b000}))
          + SUM_W'($signed(prod1[p]));
      if (!ramp1 || v[SUM_W-1]) begin
        base = '0;
      end else begin
        base = v[CH_W+2:3];
      end
      c2_next[p] = (base >= CH_W'(dim)) ? (base - CH_W'(dim)) : '0;
    end
  end

  always_comb begin
    logic signed [CH_W:0] diff;
    for (int p = 0; p < NUM_CH; p++) begin
      diff = $signed({1'b0, chan(regs.fade_color, p)}) - $signed({1'b0, c2[p]});
      d3_next[p] = FADE_W'(FADE_W'(diff) * $signed(FADE_W'({1'b0, coeff_cl})));
    end
  end

  // floor divide by sixteen is an arithmetic shift
  always_comb begin
    logic signed [FADE_W-1:0] v;
    for (int p = 0; p < NUM_CH; p++) begin
      v = $signed(FADE_W'({1'b0, c3[p]})) + ($signed(d3[p]) >>> FADE_SHIFT);
      color4_next[p*CH_W +: CH_W] = v[FADE_W-1] ? '0 : v[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= issue_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      ramp1  <= issue.ramp;
      shade1 <= issue.shade;
      prod1  <= prod1_next;
    end
    if (r2) begin
      shade2 <= shade1;
      c2     <= c2_next;
    end
    if (r3) begin
      shade3 <= shade2;
      c3     <= c2;
      d3     <= d3_next;
    end
    if (r4) begin
      shade4 <= shade3;
      color4 <= color4_next;
    end
  end

  assign palette.valid         = v4;
  assign palette.palette_color = color4;
  assign palette.shade_index   = shade4;
  assign palette.last_shade    = (shade4 == SHADE_LAST);

  `GSP_ASSERT_NEXT(a_s4_hold, v4 && !palette.ready, v4 && (shade4 == $past(shade4)) && (color4 == $past(color4)), "stalled word changed")

endmodule

/* rtl/core/gradient_shade_palette_gen_core.sv */
// Top level: gradient shade palette generator, 16 RGB555 words per line.
// Path: a taken line word loads the sequencer, whose shade words then pass pipeline stages 1 to 4 to the output.
// Throughput: one palette word per cycle unless palette.ready stalls it; the
//   single shade sequencer issues one shade a cycle unless stalled, and takes
//   the next line as its sixteenth shade leaves, so lines run back to back.
// Reset: synchronous rst clears all valids, the sequencer and the four config
//   registers (to 0); pipeline data registers are not reset.
`timescale 1ns / 1ps
module gradient_shade_palette_gen_core import gsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  gsp_cfg_if.sink     cfg,
  gsp_line_if.sink    req,
  gsp_entry_if.source palette
);

  // Config registers, read live by the stages. Writes must come only while idle; the block does not enforce it.
  cfg_t   regs;

  // Sequencer to pipeline: one shade word per cycle while issue_ready is high.
  logic   issue_valid;
  logic   issue_ready;
  issue_t issue;

  gsp_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Clamps the line, looks up the per-channel ramp step, counts shades 0..15.
  gsp_line_seq u_line_seq (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .req         (req),
    .issue_valid (issue_valid),
    .issue       (issue),
    .issue_ready (issue_ready)
  );

  // Four register stages:
  //   1: k * step per channel
  //   2: base = (start*8 + k*step) >> 3, 0 if not a ramp line or negative, then dim by (shade>>2)+2 floored at 0
  //   3: (blend - c) * coeff
  //   4: c + floor(product / 16), packed into RGB555; this is the output word
  gsp_shade_pipe u_shade_pipe (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .issue_valid (issue_valid),
    .issue       (issue),
    .issue_ready (issue_ready),
    .palette     (palette)
  );

endmodule

/* tb/palette_tracker_pkg.sv */
// Palette tracker class: expected shade words per line and their checking.
`timescale 1ns / 1ps
package palette_tracker_pkg;
  import gsp_pkg::*;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [SHADE_W-1:0] shade;
    logic               is_last;
  } palette_entry_t;

  class palette_tracker;
    logic [COLOR_W-1:0] start_color;
    logic [COLOR_W-1:0] stop_color;
    logic [COEFF_W-1:0] blend_coeff;
    logic [COLOR_W-1:0] fade_color;
    palette_entry_t     awaited[$];
    int                 failures;

    function new();
      start_color = '0;
      stop_color  = '0;
      blend_coeff = '0;
      fade_color  = '0;
      failures    = 0;
    endfunction

    // register writes keep only the register width
    function void note_write(cfg_reg_t idx, logic [COLOR_W-1:0] data);
      case (idx)
        REG_START_COLOR: start_color = data;
        REG_STOP_COLOR:  stop_color  = data;
        REG_BLEND_COEFF: blend_coeff = data[COEFF_W-1:0];
        REG_FADE_COLOR:  fade_color  = data;
        default: ;
      endcase
    endfunction

    // channel level on a ramp line, k = line - 2; step truncates toward zero
    function int ramp_level(int s, int e, int k);
      int step;
      int v;
      step = (e * 8 - s * 8) / (GRADIENT_LINES - 2);
      v = s * 8 + k * step;
      if (v < 0) v = 0;
      return (v >> 3) & 'h1f;
    endfunction

    // fade toward target by coeff/16, floor on negative differences
    function int fade_level(int c, int target, int coeff);
      int v;
      v = c + (((target - c) * coeff) >>> 4);
      if (v < 0) v = 0;
      return v & 'h1f;
    endfunction

    function void add_line(logic [LINE_W-1:0] line_index);
      int             ln;
      int             coeff;
      int             dim;
      int             c;
      int             base[NUM_CH];
      palette_entry_t entry;
      ln = line_index;
      if (ln >= GRADIENT_LINES) ln = GRADIENT_LINES - 1;
      coeff = (blend_coeff > COEFF_MAX) ? COEFF_MAX : int'(blend_coeff);
      for (int p = 0; p < NUM_CH; p++) begin
        if (ln < 2) base[p] = 0;
        else base[p] = ramp_level(start_color[p*CH_W +: CH_W], stop_color[p*CH_W +: CH_W],
                                  ln - 2);
      end
      for (int j = 0; j < SHADES_PER_LINE; j++) begin
        dim = (j >> 2) + 2;
        entry.color = '0;
        for (int p = 0; p < NUM_CH; p++) begin
          c = (base[p] >= dim) ? base[p] - dim : 0;
          c = fade_level(c, fade_color[p*CH_W +: CH_W], coeff);
          entry.color[p*CH_W +: CH_W] = c[CH_W-1:0];
        end
        entry.shade   = j[SHADE_W-1:0];
        entry.is_last = (j == SHADES_PER_LINE - 1);
        awaited.push_back(entry);
      end
    endfunction

    function void check_word(logic [COLOR_W-1:0] color, logic [SHADE_W-1:0] shade,
                             logic is_last);
      palette_entry_t want;
      if (awaited.size() == 0) begin
        $display("%0t: palette word %h shade %0d with no line pending", $time, color, shade);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (color !== want.color) begin
        $display("%0t: palette_color expected %h actual %h (shade %0d)",
                 $time, want.color, color, want.shade);
        failures++;
      end
      if (shade !== want.shade) begin
        $display("%0t: shade_index expected %0d actual %0d", $time, want.shade, shade);
        failures++;
      end
      if (is_last !== want.is_last) begin
        $display("%0t: last_shade expected %b actual %b (shade %0d)",
                 $time, want.is_last, is_last, want.shade);
        failures++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

/* tb/testbench.sv */
// Testbench top: drives line requests and register writes, checks every palette word.
`timescale 1ns / 1ps
module testbench import gsp_pkg::*, palette_tracker_pkg::*;;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int LONG_HOLD_CYCLES = 80;   // well past the block's internal buffering
  localparam int DRAIN_CYCLES     = 16;
  localparam int RANDOM_PHASES    = 12;
  localparam int LINES_PER_PHASE  = 35;

  logic clk = 1'b0;
  logic rst;

  gsp_cfg_if   cfg_ch();
  gsp_line_if  line_ch();
  gsp_entry_if pal_ch();

  gradient_shade_palette_gen_core dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .req     (line_ch),
    .palette (pal_ch)
  );

  palette_tracker book = new();

  // idle odds in percent per side; main flow retunes them per phase
  int sender_idle_pct = 25;
  int sink_idle_pct   = 25;
  bit long_hold_req   = 1'b0;
  int cycle_count     = 0;

  always #10 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Everything is sampled at the rising edge, before the block's own updates land.
  // Register writes update the tracker copy, each accepted line queues its
  // sixteen words, each accepted word is checked against the oldest one.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        book.note_write(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (line_ch.valid && line_ch.ready)
        book.add_line(line_ch.line_index);
      if (pal_ch.valid && pal_ch.ready)
        book.check_word(pal_ch.palette_color, pal_ch.shade_index, pal_ch.last_shade);
    end
  end

  // Palette word receiver. Short random stalls, plus one long hold-off on
  // request so the pipeline backs up and the line port has to stall.
  initial begin
    pal_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        pal_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        pal_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < sink_idle_pct) begin
        pal_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        pal_ch.ready <= 1'b1;
      end else begin
        pal_ch.ready <= 1'b1;
      end
    end
  end

  // Present one line word and hold it until taken. Valid stays up on return so
  // back-to-back lines never drop it; callers lower it only ahead of a gap.
  task automatic send_line(input logic [LINE_W-1:0] ln);
    line_ch.valid      <= 1'b1;
    line_ch.line_index <= ln;
    do @(posedge clk); while (!line_ch.ready);
    @(negedge clk);
  endtask

  // Optional random idle burst ahead of the line.
  task automatic offer_line(input logic [LINE_W-1:0] ln);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      line_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    send_line(ln);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COLOR_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // All four registers, back to back; only called with nothing in flight.
  task automatic program_colors(input logic [COLOR_W-1:0] start_c,
                                input logic [COLOR_W-1:0] stop_c,
                                input logic [COLOR_W-1:0] coeff_word,
                                input logic [COLOR_W-1:0] blend_c);
    write_reg(REG_START_COLOR, start_c);
    write_reg(REG_STOP_COLOR, stop_c);
    write_reg(REG_BLEND_COEFF, coeff_word);
    write_reg(REG_FADE_COLOR, blend_c);
    cfg_ch.valid <= 1'b0;
  endtask

  // Close a phase: stop offering and wait for every queued word to arrive.
  task automatic drain_lines();
    line_ch.valid <= 1'b0;
    do @(negedge clk); while (book.outstanding() != 0);
  endtask

  // Colors lean on black and white so the ramp ends get hit often.
  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // Coefficient word: junk in the upper bits, low five bits spread over the
  // in-range values, sixteen, and the clamped range above it.
  function automatic logic [COLOR_W-1:0] pick_coeff_word();
    logic [COEFF_W-1:0]         low;
    logic [COLOR_W-COEFF_W-1:0] upper;
    upper = (COLOR_W - COEFF_W)'($urandom);
    case ($urandom_range(0, 5))
      0:       low = '0;
      1:       low = COEFF_W'(COEFF_MAX);
      2:       low = '1;
      3:       low = COEFF_W'($urandom_range(COEFF_MAX + 1, 31));
      default: low = COEFF_W'($urandom_range(0, COEFF_MAX));
    endcase
    return {upper, low};
  endfunction

  initial begin
    rst                = 1'b1;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_START_COLOR;
    cfg_ch.data        = '0;
    line_ch.valid      = 1'b0;
    line_ch.line_index = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // reset values: all black, no fade
    send_line(5'd0);
    send_line(5'd31);
    drain_lines();

    // rising ramp black to white, no fade; both black lines, first ramp
    // lines, middle and the bottom line
    program_colors('0, '1, '0, '0);
    offer_line(5'd0);
    offer_line(5'd1);
    offer_line(5'd2);
    offer_line(5'd3);
    offer_line(5'd16);
    offer_line(5'd30);
    offer_line(5'd31);
    drain_lines();

    // falling ramp (negative step), full fade to white
    program_colors('1, '0, COLOR_W'(COEFF_MAX), '1);
    offer_line(5'd2);
    offer_line(5'd15);
    offer_line(5'd31);
    drain_lines();

    // coefficient all ones acts as sixteen: everything fades to the blend color
    program_colors(15'h7c1f, 15'h03e0, 15'h001f, '0);
    offer_line(5'd2);
    offer_line(5'd20);
    offer_line(5'd31);
    drain_lines();

    // coefficient just above the clamp point
    program_colors(15'h1234, 15'h6b5a, 15'd17, 15'h4210);
    offer_line(5'd5);
    offer_line(5'd31);
    drain_lines();

    // fading down toward black: negative difference, floor rounding
    program_colors('1, '1, 15'd5, '0);
    offer_line(5'd2);
    offer_line(5'd9);
    drain_lines();

    // upper bits of the coefficient word must be dropped (acts as 3)
    program_colors(15'h3def, 15'h0421, 15'h7fe3, '1);
    offer_line(5'd4);
    offer_line(5'd27);
    drain_lines();

    // ---- random part ----
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_colors(pick_color(), pick_color(), pick_coeff_word(), pick_color());
      if (ph == 0) begin
        // long receiver hold-off with the sender streaming flat out
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
        long_hold_req   = 1'b1;
      end else if (ph == 4 || ph == RANDOM_PHASES - 1) begin
        // stretches with no idling at all; the last phase stays that way
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
      end else begin
        sender_idle_pct = $urandom_range(10, 40);
        sink_idle_pct   = $urandom_range(10, 40);
      end
      for (int n = 0; n < LINES_PER_PHASE; n++)
        offer_line(LINE_W'($urandom));
      drain_lines();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/gsp_pkg.sv
rtl/core/gsp_cfg_if.sv
rtl/core/gsp_line_if.sv
rtl/core/gsp_entry_if.sv
rtl/core/gsp_cfg_regs.sv
rtl/core/gsp_line_seq.sv
rtl/core/gsp_shade_pipe.sv
rtl/core/gradient_shade_palette_gen_core.sv
tb/palette_tracker_pkg.sv
tb/testbench.sv
